@@ design/dgd_pkg.sv @@
package dgd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  dgram_type;
        logic [7:0]  dgram_index;
        logic [10:0] dgram_length;
        logic [10:0] data_offset;
        logic [7:0]  data_byte;
        logic [15:0] wkc_value;
        logic        more_follows;
    } t_out_item;

    typedef enum logic [4:0] {
        PH_SKIP = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_WKC  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [10:0] DG_HDR_LEN     = 11'd10;
    localparam logic [10:0] HDR_POS_TYPE   = 11'd0;
    localparam logic [10:0] HDR_POS_INDEX  = 11'd1;
    localparam logic [10:0] HDR_POS_LEN_LO = 11'd6;
    localparam logic [10:0] HDR_POS_LEN_HI = 11'd7;

    localparam logic [7:0] LEN_HIGH_MASK = 8'h07;
    localparam logic [7:0] MORE_MASK     = 8'h80;

endpackage

@@ design/dgd_in_stage.sv @@
module dgd_in_stage
    import dgd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_data
);

    logic     r_valid;
    t_in_item r_data;

    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

@@ design/dgd_parser.sv @@
module dgd_parser
    import dgd_pkg::*;
#(
    parameter int HEADER_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    output logic      o_advance,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam logic [10:0] SkipLen = 11'(HEADER_BYTES);

    t_phase      r_phase, n_phase;
    logic [10:0] r_cnt, n_cnt;
    logic [7:0]  r_held_type, n_held_type;
    logic [7:0]  r_held_index, n_held_index;
    logic [10:0] r_held_length, n_held_length;
    logic        r_held_more, n_held_more;
    logic [7:0]  r_counter_low, n_counter_low;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        res_valid;
    t_out_item   res_data;
    logic [10:0] cnt_inc;
    logic [2:0]  len_hi;

    assign o_advance   = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign cnt_inc     = r_cnt + 11'd1;
    assign len_hi      = i_item.rx_byte[2:0] & LEN_HIGH_MASK[2:0];

    always_comb begin
        n_phase       = r_phase;
        n_cnt         = r_cnt;
        n_held_type   = r_held_type;
        n_held_index  = r_held_index;
        n_held_length = r_held_length;
        n_held_more   = r_held_more;
        n_counter_low = r_counter_low;
        res_valid     = 1'b0;
        res_data                 = '0;
        res_data.dgram_type      = r_held_type;
        res_data.dgram_index     = r_held_index;
        res_data.dgram_length    = r_held_length;
        res_data.more_follows    = r_held_more;

        if (i_item.frame_start) begin
            n_phase = PH_SKIP;
            n_cnt   = 11'd1;
            if (11'd1 >= SkipLen) begin
                n_phase = PH_HDR;
                n_cnt   = '0;
            end
        end else begin
            case (r_phase)
                PH_SKIP: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= SkipLen) begin
                        n_phase = PH_HDR;
                        n_cnt   = '0;
                    end
                end
                PH_HDR: begin
                    case (r_cnt)
                        HDR_POS_TYPE:   n_held_type  = i_item.rx_byte;
                        HDR_POS_INDEX:  n_held_index = i_item.rx_byte;
                        HDR_POS_LEN_LO: n_held_length = {r_held_length[10:8], i_item.rx_byte};
                        HDR_POS_LEN_HI: begin
                            n_held_length = {len_hi, r_held_length[7:0]};
                            n_held_more   = |(i_item.rx_byte & MORE_MASK);
                        end
                        default: ;
                    endcase
                    n_cnt = cnt_inc;
                    if (cnt_inc >= DG_HDR_LEN) begin
                        n_cnt   = '0;
                        n_phase = (n_held_length == 11'd0) ? PH_WKC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    res_valid            = 1'b1;
                    res_data.kind        = KIND_DATA;
                    res_data.data_offset = r_cnt;
                    res_data.data_byte   = i_item.rx_byte;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_held_length) begin
                        n_cnt   = '0;
                        n_phase = PH_WKC;
                    end
                end
                PH_WKC: begin
                    if (r_cnt == 11'd0) begin
                        n_counter_low = i_item.rx_byte;
                        n_cnt         = 11'd1;
                    end else begin
                        res_valid          = 1'b1;
                        res_data.kind      = KIND_RECORD;
                        res_data.wkc_value = {i_item.rx_byte, r_counter_low};
                        n_cnt   = '0;
                        n_phase = r_held_more ? PH_HDR : PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= o_advance && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_held_type   <= n_held_type;
            r_held_index  <= n_held_index;
            r_held_length <= n_held_length;
            r_held_more   <= n_held_more;
            r_counter_low <= n_counter_low;
            if (res_valid) begin
                r_out_data <= res_data;
            end
        end
    end

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_cnt < DG_HDR_LEN))
        else $error("Header byte count has run past the datagram header.");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_held_length))
        else $error("Data offset has reached the datagram length.");

    a_wkc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WKC) |-> (r_cnt <= 11'd1))
        else $error("Working counter byte count is out of range.");

    a_start_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_item.frame_start) |=> (r_phase == PH_SKIP))
        else $error("A frame start did not restart the header skip.");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.kind == KIND_DATA)
            |-> (r_out_data.data_offset < r_out_data.dgram_length))
        else $error("A data byte carries an offset beyond its datagram length.");

endmodule

@@ design/ethercat_datagram_deframer_core.sv @@
// Channel  Valid         Stall         Payload
// input    i_in_valid    o_in_stall    i_in_data  (t_in_item: rx_byte, frame_start)
// output   o_out_valid   i_out_stall   o_out_data (t_out_item: data byte or record)
//
// One request is accepted per cycle unless stalled; any result passes through the result register.
// The rate is set by the single input register and the result register around the parser.
// A frame start restarts parsing at once, even in the middle of a datagram.
// Reset is synchronous and leaves the parser waiting for a frame start.
// An output stall holds the result and stalls the input only when both registers are full.
module ethercat_datagram_deframer_core
    import dgd_pkg::*;
#(
    parameter int HEADER_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic     item_valid;
    t_in_item item_data;
    logic     advance;

    dgd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_stall   (o_in_stall),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_data    (item_data)
    );

    dgd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item_data),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

@@ test/ethercat_datagram_deframer_checker.sv @@
module ethercat_datagram_deframer_checker
    import dgd_pkg::*;
#(
    parameter int HEADER_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_data_checked,
    output int        o_records_checked
);

    t_phase      parse_phase = PH_DONE;
    logic [10:0] parse_count = '0;
    logic [7:0]  cur_type    = '0;
    logic [7:0]  cur_index   = '0;
    logic [10:0] cur_length  = '0;
    logic        cur_more    = 1'b0;
    logic [7:0]  wkc_low     = '0;

    t_out_item expected_results[$];

    int fail_count      = 0;
    int result_count    = 0;
    int data_checked    = 0;
    int records_checked = 0;

    task automatic note_mismatch(input string what);
        $display("Mismatch at result %0d: %s", result_count, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic push_result(input logic kind, input logic [10:0] offset,
                               input logic [7:0] data, input logic [15:0] wkc);
        t_out_item res;
        res.kind         = kind;
        res.dgram_type   = cur_type;
        res.dgram_index  = cur_index;
        res.dgram_length = cur_length;
        res.data_offset  = offset;
        res.data_byte    = data;
        res.wkc_value    = wkc;
        res.more_follows = cur_more;
        expected_results.push_back(res);
    endtask

    // Walks the frame parse by one accepted request and queues the result it causes.
    task automatic advance_parser(input t_in_item req);
        logic [7:0] b;
        b = req.rx_byte;
        if (req.frame_start) begin
            parse_phase = PH_SKIP;
            parse_count = 11'd1;
            if (parse_count >= HEADER_BYTES) begin
                parse_phase = PH_HDR;
                parse_count = '0;
            end
        end else begin
            case (parse_phase)
                PH_SKIP: begin
                    parse_count = parse_count + 11'd1;
                    if (parse_count >= HEADER_BYTES) begin
                        parse_phase = PH_HDR;
                        parse_count = '0;
                    end
                end
                PH_HDR: begin
                    if (parse_count == HDR_POS_TYPE) begin
                        cur_type = b;
                    end else if (parse_count == HDR_POS_INDEX) begin
                        cur_index = b;
                    end else if (parse_count == HDR_POS_LEN_LO) begin
                        cur_length[7:0] = b;
                    end else if (parse_count == HDR_POS_LEN_HI) begin
                        cur_length[10:8] = 3'(b & LEN_HIGH_MASK);
                        cur_more         = |(b & MORE_MASK);
                    end
                    parse_count = parse_count + 11'd1;
                    if (parse_count >= DG_HDR_LEN) begin
                        parse_count = '0;
                        parse_phase = (cur_length == '0) ? PH_WKC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    push_result(KIND_DATA, parse_count, b, 16'h0000);
                    parse_count = parse_count + 11'd1;
                    if (parse_count >= cur_length) begin
                        parse_count = '0;
                        parse_phase = PH_WKC;
                    end
                end
                PH_WKC: begin
                    if (parse_count == '0) begin
                        wkc_low     = b;
                        parse_count = 11'd1;
                    end else begin
                        push_result(KIND_RECORD, 11'd0, 8'h00, {b, wkc_low});
                        parse_count = '0;
                        parse_phase = cur_more ? PH_HDR : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            parse_phase = PH_DONE;
            parse_count = '0;
            cur_type    = '0;
            cur_index   = '0;
            cur_length  = '0;
            cur_more    = 1'b0;
            wkc_low     = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    note_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 16'(i_out_data.kind), 16'(want.kind));
                    check_field("dgram_type", 16'(i_out_data.dgram_type),
                                16'(want.dgram_type));
                    check_field("dgram_index", 16'(i_out_data.dgram_index),
                                16'(want.dgram_index));
                    check_field("dgram_length", 16'(i_out_data.dgram_length),
                                16'(want.dgram_length));
                    check_field("data_offset", 16'(i_out_data.data_offset),
                                16'(want.data_offset));
                    check_field("data_byte", 16'(i_out_data.data_byte),
                                16'(want.data_byte));
                    check_field("wkc_value", i_out_data.wkc_value, want.wkc_value);
                    check_field("more_follows", 16'(i_out_data.more_follows),
                                16'(want.more_follows));
                    if (want.kind == KIND_RECORD) begin
                        records_checked++;
                    end else begin
                        data_checked++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_parser(i_in_data);
            end
        end
        o_fail_count      <= fail_count;
        o_pending         <= expected_results.size();
        o_data_checked    <= data_checked;
        o_records_checked <= records_checked;
    end

endmodule

@@ test/tb_ethercat_datagram_deframer_core.sv @@
module tb_ethercat_datagram_deframer_core;
    import dgd_pkg::*;

    localparam int SKIP_BYTES   = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_item  in_data     = '0;
    logic      out_stall   = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int data_checked;
    int records_checked;

    logic     quiet_spell = 1'b0;
    int       stall_left  = 0;
    t_in_item frame_q[$];

    int bytes_sent   = 0;
    int frames_sent  = 0;
    int frames_cut   = 0;
    int noise_bursts = 0;

    ethercat_datagram_deframer_core #(
        .HEADER_BYTES(SKIP_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    ethercat_datagram_deframer_checker #(
        .HEADER_BYTES(SKIP_BYTES)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (o_out_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_data_checked   (data_checked),
        .o_records_checked(records_checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n || quiet_spell) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(1, 8);
            end else if (r < 95) begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end else begin
            stall_left--;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_spell || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start);
        t_in_item req;
        req.rx_byte     = b;
        req.frame_start = start;
        frame_q.push_back(req);
    endtask

    task automatic push_frame_header();
        push_byte(8'($urandom), 1'b1);
        for (int k = 1; k < SKIP_BYTES; k++) begin
            push_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic push_dgram(input logic [7:0] dg_type, input logic [7:0] dg_index,
                              input logic [10:0] len, input logic more,
                              input logic [15:0] wkc);
        logic [7:0] b;
        for (int p = 0; p < DG_HDR_LEN; p++) begin
            case (11'(p))
                HDR_POS_TYPE:   b = dg_type;
                HDR_POS_INDEX:  b = dg_index;
                HDR_POS_LEN_LO: b = len[7:0];
                HDR_POS_LEN_HI: b = {more, 4'($urandom), len[10:8]};
                default:        b = 8'($urandom);
            endcase
            push_byte(b, 1'b0);
        end
        for (int k = 0; k < len; k++) begin
            push_byte(8'($urandom), 1'b0);
        end
        push_byte(wkc[7:0], 1'b0);
        push_byte(wkc[15:8], 1'b0);
    endtask

    task automatic push_padding(input int count);
        for (int k = 0; k < count; k++) begin
            push_byte(8'($urandom), 1'b0);
        end
    endtask

    function automatic logic [10:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 11'd0;
        end else if (r < 80) begin
            return 11'($urandom_range(1, 6));
        end else if (r < 97) begin
            return 11'($urandom_range(7, 40));
        end
        return 11'($urandom_range(41, 200));
    endfunction

    task automatic push_random_frame();
        int n;
        n = $urandom_range(1, 4);
        push_frame_header();
        for (int d = 0; d < n; d++) begin
            push_dgram(8'($urandom), 8'($urandom), pick_length(),
                       (d != n - 1) || ($urandom_range(0, 19) == 0), 16'($urandom));
        end
        push_padding($urandom_range(0, 6));
    endtask

    // Sends the first count queued requests, each after a random gap, then clears the queue.
    task automatic send_queued(input int count);
        int gap;
        for (int k = 0; k < count && k < frame_q.size(); k++) begin
            gap = idle_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_data  <= frame_q[k];
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            bytes_sent++;
        end
        frame_q.delete();
    endtask

    initial begin
        int directed_bytes;
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes ahead of any frame start must be ignored.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        send_queued(frame_q.size());

        // A zero-length datagram followed by a one-byte last datagram and padding.
        push_frame_header();
        push_dgram(8'hFF, 8'h00, 11'd0, 1'b1, 16'hFFFF);
        push_dgram(8'h00, 8'hFF, 11'd1, 1'b0, 16'h0000);
        push_padding(2);
        send_queued(frame_q.size());
        frames_sent++;

        // A maximum-length datagram cut short after its first three data bytes; a later frame start ends it.
        push_frame_header();
        push_dgram(8'hA5, 8'h5A, 11'h7FF, 1'b1, 16'h1234);
        send_queued(SKIP_BYTES + DG_HDR_LEN + 3);
        frames_cut++;

        directed_bytes = bytes_sent;
        while (bytes_sent < directed_bytes + RANDOM_ITEMS) begin
            quiet_spell <= ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 78) begin
                push_random_frame();
                send_queued(frame_q.size());
                frames_sent++;
            end else if (r < 91) begin
                push_random_frame();
                send_queued($urandom_range(1, frame_q.size() - 1));
                frames_cut++;
            end else begin
                for (int k = $urandom_range(1, 8); k > 0; k--) begin
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
                send_queued(frame_q.size());
                noise_bursts++;
            end
        end

        // One complete long datagram whose data offsets run past one byte.
        quiet_spell <= 1'b0;
        push_frame_header();
        push_dgram(8'($urandom), 8'($urandom), 11'd300, 1'b0, 16'($urandom));
        send_queued(frame_q.size());
        frames_sent++;

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes: %0d whole frames, %0d cut short, %0d bursts of noise.",
                 bytes_sent, frames_sent, frames_cut, noise_bursts);
        $display("Checked %0d data bytes and %0d datagram records, %0d mismatches.",
                 data_checked, records_checked, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/dgd_pkg.sv
design/dgd_in_stage.sv
design/dgd_parser.sv
design/ethercat_datagram_deframer_core.sv
test/ethercat_datagram_deframer_checker.sv
test/tb_ethercat_datagram_deframer_core.sv
